### design/ffa_pkg.sv
// shared types and constants of the first-fit free-list allocator
package ffa_pkg;

	localparam int unsigned ARENA_BYTES  = 65536;
	localparam int unsigned OFFSET_SPAN  = 65536;
	localparam int unsigned USABLE_BYTES = (ARENA_BYTES < OFFSET_SPAN) ? ARENA_BYTES : OFFSET_SPAN;
	localparam int unsigned HDR_BYTES    = 8;
	localparam int unsigned SLOT_BITS    = 13;
	localparam int unsigned SLOT_COUNT   = 1 << SLOT_BITS;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} ffa_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_BAD_SIG = 2'd2,
		ST_BAD_OFF = 2'd3
	} ffa_status_t;

	// compact header tag: signature flag, link-valid flag, next block index
	typedef struct packed {
		logic                 sig;
		logic                 lv;
		logic [SLOT_BITS-1:0] idx;
	} ffa_tag_t;

	typedef struct packed {
		ffa_op_t     opcode;
		logic [16:0] request_bytes;
		logic [15:0] release_offset;
	} ffa_in_word_t;

	typedef struct packed {
		logic [15:0] user_offset;
		ffa_status_t status;
	} ffa_out_word_t;

endpackage

### design/first_fit_free_list_allocator_core.sv
// first-fit free-list allocator core: header memories, list walk and result register
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | opcode, request_bytes, release_offset
//  out     | output    | out_valid / out_ready| user_offset, status
//
// one word is in flight at a time. an allocate served by the break passes S_BUMP; an
// allocate that visits free blocks reads one header per cycle in S_WALK, on the single read
// port of the tag and size memories, then goes to S_FIN or S_BUMP. a release passes S_RELCHK
// or S_DONE. after reset the tag memory is cleared one entry a cycle, with in_ready low.
// a result waits in the output register; the core holds its last step while out is stalled.
module first_fit_free_list_allocator_core
	import ffa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ffa_in_word_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ffa_out_word_t out_data
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_WALK   = 7'b0000100,
		S_FIN    = 7'b0001000,
		S_BUMP   = 7'b0010000,
		S_RELCHK = 7'b0100000,
		S_DONE   = 7'b1000000
	} ffa_state_t;

	localparam ffa_tag_t TAG_SIG  = '{sig: 1'b1, lv: 1'b0, idx: '0};
	localparam ffa_tag_t TAG_NONE = '{sig: 1'b0, lv: 1'b0, idx: '0};

	// control state
	ffa_state_t           state_q;
	logic [SLOT_BITS-1:0] clr_q;
	logic [16:0]          bp_q;
	logic                 head_valid_q;
	logic [SLOT_BITS-1:0] head_q;
	logic                 prev_ok_q;
	logic                 out_valid_q;

	// payload
	logic [SLOT_BITS-1:0] prev_q;
	logic [SLOT_BITS-1:0] cur_q;
	logic [17:0]          need_q;
	ffa_out_word_t        out_data_q;

	// header memories
	ffa_tag_t             tag_mem [SLOT_COUNT];
	logic [16:0]          size_mem [SLOT_COUNT];
	ffa_tag_t             tag_rd_q;
	logic [16:0]          size_rd_q;

	logic                 tag_we;
	logic [SLOT_BITS-1:0] tag_wa;
	ffa_tag_t             tag_wd;
	logic                 size_we;
	logic [SLOT_BITS-1:0] rd_addr;

	logic                 accept;
	logic                 can_emit;
	logic [17:0]          req_round;
	logic [17:0]          need_in;
	logic [15:0]          rel_start;
	logic                 rel_bad;
	logic [18:0]          bump_end;
	logic                 bump_oom;
	logic                 fits;
	logic                 emit;
	ffa_out_word_t        emit_word;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign can_emit  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// size with header, rounded up to the 8-byte grain
	assign req_round = {1'b0, in_data.request_bytes} + 18'd7;
	assign need_in   = {req_round[17:3] + 15'd1, 3'b000};

	// release range check against the break
	assign rel_start = in_data.release_offset - 16'(HDR_BYTES);
	assign rel_bad   = (in_data.release_offset[2:0] != 3'b000)
		|| (in_data.release_offset < 16'(HDR_BYTES))
		|| ({1'b0, rel_start} >= bp_q);

	// bump overflow: past arena end, or user offset not fitting 16 bits
	assign bump_end = {2'b00, bp_q} + {1'b0, need_q};
	assign bump_oom = (bump_end > 19'(USABLE_BYTES))
		|| (({2'b00, bp_q} + 19'(HDR_BYTES)) >= 19'(OFFSET_SPAN));

	// first-fit test on the header just read
	assign fits = ({1'b0, size_rd_q} >= need_q);

	// read address: head on allocate, header slot on release, link while walking
	always_comb begin
		rd_addr = cur_q;
		if (state_q == S_IDLE) begin
			if (in_data.opcode == OP_ALLOC) begin
				rd_addr = head_q;
			end else begin
				rd_addr = rel_start[15:3];
			end
		end else if (state_q == S_WALK) begin
			rd_addr = tag_rd_q.idx;
		end
	end

	// single write port per memory
	always_comb begin
		tag_we  = 1'b0;
		tag_wa  = cur_q;
		tag_wd  = TAG_SIG;
		size_we = 1'b0;
		case (state_q)
			S_CLEAR: begin
				tag_we = 1'b1;
				tag_wa = clr_q;
				tag_wd = TAG_NONE;
			end
			S_WALK: begin
				// unlink: predecessor takes over the link of the chosen block
				if (fits && prev_ok_q) begin
					tag_we = 1'b1;
					tag_wa = prev_q;
					tag_wd = tag_rd_q;
				end
			end
			S_FIN: begin
				tag_we = can_emit;
			end
			S_BUMP: begin
				tag_we  = can_emit && !bump_oom;
				size_we = can_emit && !bump_oom;
				tag_wa  = bp_q[15:3];
			end
			S_RELCHK: begin
				// push on the list head
				tag_we = can_emit && tag_rd_q.sig;
				tag_wd = head_valid_q ? ffa_tag_t'{sig: 1'b0, lv: 1'b1, idx: head_q}
					: TAG_NONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (size_we) begin
			size_mem[tag_wa] <= need_q[16:0];
		end
		tag_rd_q  <= tag_mem[rd_addr];
		size_rd_q <= size_mem[rd_addr];
	end

	// result word
	always_comb begin
		emit      = 1'b0;
		emit_word = '{user_offset: '0, status: ST_OK};
		case (state_q)
			S_FIN: begin
				emit                  = can_emit;
				emit_word.user_offset = {cur_q, 3'b000} + 16'(HDR_BYTES);
			end
			S_BUMP: begin
				emit = can_emit;
				if (bump_oom) begin
					emit_word.status = ST_OOM;
				end else begin
					emit_word.user_offset = bp_q[15:0] + 16'(HDR_BYTES);
				end
			end
			S_RELCHK: begin
				emit = can_emit;
				if (!tag_rd_q.sig) begin
					emit_word.status = ST_BAD_SIG;
				end
			end
			S_DONE: begin
				emit             = can_emit;
				emit_word.status = ST_BAD_OFF;
			end
			default: begin
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			bp_q         <= '0;
			head_valid_q <= 1'b0;
			head_q       <= '0;
			prev_ok_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						prev_ok_q <= 1'b0;
						if (in_data.opcode == OP_ALLOC) begin
							state_q <= head_valid_q ? S_WALK : S_BUMP;
						end else begin
							state_q <= rel_bad ? S_DONE : S_RELCHK;
						end
					end
				end
				S_WALK: begin
					if (fits) begin
						if (!prev_ok_q) begin
							head_valid_q <= tag_rd_q.lv;
							head_q       <= tag_rd_q.lv ? tag_rd_q.idx : '0;
						end
						state_q <= S_FIN;
					end else begin
						prev_ok_q <= 1'b1;
						if (!tag_rd_q.lv) begin
							state_q <= S_BUMP;
						end
					end
				end
				S_FIN: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				S_BUMP: begin
					if (can_emit) begin
						if (!bump_oom) begin
							bp_q <= bump_end[16:0];
						end
						state_q <= S_IDLE;
					end
				end
				S_RELCHK: begin
					if (can_emit) begin
						if (tag_rd_q.sig) begin
							head_valid_q <= 1'b1;
							head_q       <= cur_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= emit_word;
		end
		if (accept) begin
			need_q <= need_in;
			if (in_data.opcode == OP_ALLOC) begin
				cur_q <= head_q;
			end else begin
				cur_q <= rel_start[15:3];
			end
		end else if (state_q == S_WALK && !fits) begin
			prev_q <= cur_q;
			cur_q  <= tag_rd_q.idx;
		end
	end

endmodule

### design/ffa_checker.sv
// port checker of the allocator core and its bind
module ffa_checker
	import ffa_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input ffa_in_word_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input ffa_out_word_t out_data
);

	// waiting input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("waiting input word changed");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result word changed");

	// one word in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// failures carry a zero offset
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.user_offset == 16'd0)
		else $error("failed result with nonzero offset");

	// granted offsets are header-aligned
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OK && out_data.user_offset != 16'd0
		|-> out_data.user_offset[2:0] == 3'b000)
		else $error("misaligned user offset");

endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (.*);

### tb/testbench.sv
// self-checking testbench for the first-fit free-list allocator core
`timescale 1ns / 100ps

module testbench;
	import ffa_pkg::*;

	localparam logic [31:0] SIGNATURE  = 32'hDEADBEEF;
	localparam logic [31:0] LINK_VALID = 32'h0000_2000;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned PRINT_CAP = 200;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ffa_in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ffa_out_word_t out_data;

	first_fit_free_list_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// words waiting to be offered, and results owed by the core, oldest first
	ffa_in_word_t  pending_words[$];
	ffa_out_word_t awaited_words[$];
	// user offsets handed out by successful allocates, used to build sensible releases
	int unsigned   live_offsets[$];

	// arena bookkeeping: header tag/link and size per 8-byte slot, break and list head
	bit [31:0] hdr_tag [SLOT_COUNT];
	bit [16:0] hdr_size [SLOT_COUNT];
	logic [16:0] brk = '0;
	logic        head_ok = 1'b0;
	logic [12:0] head_slot = '0;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_orders = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	task automatic flag_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// apply one accepted word to the arena bookkeeping and return the result it must give
	function automatic ffa_out_word_t serve_request(input ffa_in_word_t w);
		ffa_out_word_t res;
		logic [31:0] need, start, link, off;
		logic [12:0] cur, prev;
		bit found, prev_ok;
		int unsigned steps;
		res.user_offset = '0;
		res.status = ST_OK;
		if (w.opcode == OP_ALLOC) begin
			need = ((32'(w.request_bytes) + 32'd7) & ~32'd7) + 32'd8;
			found = head_ok;
			cur = head_slot;
			prev_ok = 1'b0;
			prev = '0;
			steps = 0;
			// first fit along the free list, one header per step
			while (found && steps < SLOT_COUNT) begin
				if (32'(hdr_size[cur]) >= need)
					break;
				link = hdr_tag[cur];
				prev_ok = 1'b1;
				prev = cur;
				found = link[13] && link != SIGNATURE;
				cur = link[12:0];
				steps++;
			end
			if (steps >= SLOT_COUNT)
				found = 1'b0;
			if (found) begin
				// unlink without splitting: the block keeps its stored size
				link = hdr_tag[cur];
				if (prev_ok) begin
					hdr_tag[prev] = link;
				end else begin
					head_ok = link[13];
					head_slot = link[13] ? link[12:0] : 13'd0;
				end
				start = {16'd0, cur, 3'b000};
			end else begin
				start = 32'(brk);
				// past the arena end, or a user offset that would not fit 16 bits
				if (start + need > USABLE_BYTES || start + 32'd8 >= OFFSET_SPAN) begin
					res.status = ST_OOM;
					return res;
				end
				cur = start[15:3];
				hdr_size[cur] = need[16:0];
				brk = 17'(start + need);
			end
			hdr_tag[cur] = SIGNATURE;
			res.user_offset = 16'(start + 32'd8);
			live_offsets.push_back(start + 32'd8);
		end else begin
			off = 32'(w.release_offset);
			if (off[2:0] != 3'd0 || off < 32'd8 || off - 32'd8 >= 32'(brk)) begin
				res.status = ST_BAD_OFF;
				return res;
			end
			cur = 13'((off - 32'd8) >> 3);
			// double releases and pointers into a block land here
			if (hdr_tag[cur] != SIGNATURE) begin
				res.status = ST_BAD_SIG;
				return res;
			end
			hdr_tag[cur] = head_ok ? (LINK_VALID | 32'(head_slot)) : 32'd0;
			head_slot = cur;
			head_ok = 1'b1;
		end
		return res;
	endfunction

	// number of blocks on the free list, walked the same way the core walks it
	function automatic int unsigned free_block_count();
		int unsigned n;
		logic [12:0] cur;
		logic [31:0] link;
		bit more;
		n = 0;
		more = head_ok;
		cur = head_slot;
		while (more && n < SLOT_COUNT) begin
			n++;
			link = hdr_tag[cur];
			more = link[13] && link != SIGNATURE;
			cur = link[12:0];
		end
		return n;
	endfunction

	// driver: offer the next pending word, work out its result once accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				awaited_words.push_back(serve_request(in_data));
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, timed in its own process
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_orders) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// monitor: compare each returned word with the oldest one owed
	always @(posedge clk or negedge arst_n) begin
		ffa_out_word_t owed;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_words.size() == 0) begin
					flag_mismatch($sformatf("unexpected word offset %0d status %0d",
						out_data.user_offset, out_data.status));
				end else begin
					owed = awaited_words.pop_front();
					if (out_data.user_offset !== owed.user_offset)
						flag_mismatch($sformatf("user_offset %0d, wanted %0d",
							out_data.user_offset, owed.user_offset));
					if (out_data.status !== owed.status)
						flag_mismatch($sformatf("status %0d, wanted %0d",
							out_data.status, owed.status));
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// everything the generator does happens on the falling edge, clear of the driver

	task automatic offer_alloc(input int unsigned req);
		ffa_in_word_t w;
		while (pending_words.size() >= 4)
			@(negedge clk);
		w.opcode = OP_ALLOC;
		w.request_bytes = 17'(req);
		w.release_offset = 16'($urandom);
		pending_words.push_back(w);
	endtask

	task automatic offer_release(input int unsigned off);
		ffa_in_word_t w;
		while (pending_words.size() >= 4)
			@(negedge clk);
		w.opcode = OP_RELEASE;
		w.request_bytes = 17'($urandom_range(65536));
		w.release_offset = 16'(off);
		pending_words.push_back(w);
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || awaited_words.size() != 0)
			@(negedge clk);
	endtask

	// mostly small requests so the arena lasts, now and then a large one
	function automatic int unsigned pick_request();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 72)
			return $urandom_range(64);
		else if (r < 94)
			return $urandom_range(1024, 65);
		else if (r < 98)
			return $urandom_range(8192, 1025);
		return $urandom_range(65536);
	endfunction

	task automatic random_word();
		int unsigned r, idx, off;
		r = $urandom_range(99);
		if (r < 50) begin
			offer_alloc(pick_request());
		end else if (r < 88 && live_offsets.size() != 0) begin
			idx = $urandom_range(live_offsets.size() - 1);
			off = live_offsets[idx];
			// now and then keep the offset so it gets released twice
			if ($urandom_range(15) != 0)
				live_offsets.delete(idx);
			offer_release(off);
		end else if (r < 92 && live_offsets.size() != 0) begin
			// a pointer somewhere inside a live block
			idx = $urandom_range(live_offsets.size() - 1);
			offer_release(live_offsets[idx] + 8 * $urandom_range(4, 1));
		end else if (r < 95) begin
			offer_alloc($urandom_range(65536));
		end else if (r < 98) begin
			offer_release($urandom_range(65535));
		end else begin
			offer_release($urandom_range(8191) << 3);
		end
	endtask

	task automatic random_phase(input int unsigned idle, input int unsigned stall,
		input int unsigned count);
		idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			random_word();
	endtask

	initial begin : stimulus
		int unsigned n, b;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty arena, rounding, list reuse, bad releases, oversize
		offer_release(8);
		offer_release(0);
		offer_release(65535);
		offer_alloc(0);
		offer_alloc(1);
		offer_alloc(8);
		offer_alloc(100);
		offer_alloc(65536);
		offer_alloc(65529);
		offer_release(16);
		offer_release(16);
		offer_release(20);
		offer_release(56);
		offer_release(48);
		offer_alloc(50);
		offer_release(8);
		offer_alloc(8);
		offer_alloc(200);
		offer_release(65528);
		offer_alloc(7);
		offer_release(65520);
		wait_drained();

		random_phase(0, 0, 200);
		random_phase(86, 0, 200);
		// sender pauses until the core has answered everything
		wait_drained();
		repeat (20) @(negedge clk);
		random_phase(0, 86, 200);
		random_phase(33, 33, 200);
		// receiver holds off while the sender keeps offering, so the input backs up
		hold_orders = hold_orders + 1;
		random_phase(0, 0, 200);
		wait_drained();

		// arena end: empty the free list with zero-byte requests (each takes the head),
		// bump the break to one header short of the end, then ask for zero bytes
		n = free_block_count();
		repeat (n)
			offer_alloc(0);
		wait_drained();
		b = 32'(brk);
		if (b <= 65520)
			offer_alloc(65528 - b - 8);
		offer_alloc(0);
		offer_alloc(1);
		offer_release(65535);
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
